/* hw/rtl/vcsl_pkg.sv */
// Shared types, constants and register codes of the velocity command safety limiter.
package vcsl_pkg;

  // Stream and configuration widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SOFT_DIST    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EMERG_DIST   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LINEAR   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ANGULAR  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LIN_ACCEL    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LIN_DECEL    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_CMD_TIMEOUT  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_POSE_TIMEOUT = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_SOFT_DIST    = 16'd650;
  localparam logic [15:0] RST_EMERG_DIST   = 16'd300;
  localparam logic [14:0] RST_MAX_LINEAR   = 15'd1000;
  localparam logic [14:0] RST_MAX_ANGULAR  = 15'd4000;
  localparam logic [14:0] RST_LIN_ACCEL    = 15'd66;
  localparam logic [14:0] RST_LIN_DECEL    = 15'd40;
  localparam logic [15:0] RST_CMD_TIMEOUT  = 16'd15;
  localparam logic [15:0] RST_POSE_TIMEOUT = 16'd25;

  // Reason codes, first that holds wins
  localparam logic [2:0] RSN_NORMAL     = 3'd0;
  localparam logic [2:0] RSN_EMERGENCY  = 3'd1;
  localparam logic [2:0] RSN_CMD_STALE  = 3'd2;
  localparam logic [2:0] RSN_POSE_STALE = 3'd3;
  localparam logic [2:0] RSN_GOAL       = 3'd4;
  localparam logic [2:0] RSN_SOFT_STOP  = 3'd5;

  // Fixed limits
  localparam logic signed [12:0] FRONT_HALF_ANGLE_MRAD = 13'sd524;
  localparam logic signed [16:0] ANGULAR_STEP          = 17'sd200;
  localparam logic [15:0]        AGE_MAX               = 16'hFFFF;
  localparam logic [15:0]        NO_CLEARANCE          = 16'hFFFF;

  // Multiply and divide step counts of the serial scaling unit
  localparam int MUL_STEPS = 16;
  localparam int DIV_STEPS = 15;
  localparam int CNT_W     = 4;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  // Input transaction, first field in the lowest bits
  typedef struct packed {
    logic [5:0]         pad;
    logic [15:0]        obstacle_distance;
    logic signed [12:0] obstacle_azimuth;
    logic               obstacle_valid;
    logic               goal_is_reached;
    logic               pose_new;
    logic signed [15:0] cmd_angular;
    logic signed [15:0] cmd_linear;
    logic               cmd_new;
    logic               cmd_present;
  } in_item_t;

  // Result transaction, first field in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic [2:0]         reason_code;
    logic [15:0]        front_dist;
    logic               move_ok;
    logic               obstacle_close;
    logic               goal_flag;
    logic               pose_is_stale;
    logic               command_stale;
    logic               soft_stop_active;
    logic               emergency_active;
    logic signed [15:0] out_angular;
    logic [14:0]        out_linear;
  } out_item_t;

  // Request to the serial scaling unit: floor(mcand * mplier / divisor)
  typedef struct packed {
    logic        start;
    logic [14:0] mcand;
    logic [15:0] mplier;
    logic [15:0] divisor;
  } md_req_t;

  // Response of the serial scaling unit
  typedef struct packed {
    logic        done;
    logic [14:0] quotient;
  } md_rsp_t;

endpackage

/* hw/rtl/velocity_command_safety_limiter.sv */
// Top level of the velocity command safety limiter: tick handling, limits and slew.
//
// One input transaction is one control tick; it yields exactly one result transaction.
// A tick is captured on acceptance; the serial scaling unit then does the shift-add
// multiply of commanded speed by clearance and the restoring divide by the soft-stop
// distance, one bit per cycle, and hands off to the final limit and slew stage, which
// loads the result into the output register once that register is free. The next tick
// is accepted in the cycle after the result is loaded, even while that result still
// waits to be taken, so ticks are handled one at a time. Configuration writes take
// effect at once and are meant for idle time.
module velocity_command_safety_limiter (
  input  logic                                clk,
  input  logic                                rst_n,
  // cmd_present, cmd_new, cmd_linear[16], cmd_angular[16], pose_new, goal_is_reached,
  // obstacle_valid, obstacle_azimuth[13], obstacle_distance[16], zero fill
  input  logic [vcsl_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_linear[15], out_angular[16], emergency_active, soft_stop_active, command_stale,
  // pose_is_stale, goal_flag, obstacle_close, move_ok, front_dist[16],
  // reason_code[3], zero fill
  output logic [vcsl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [vcsl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [vcsl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import vcsl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Configuration registers
  logic [15:0] soft_dist_r;
  logic [15:0] emerg_dist_r;
  logic [14:0] max_lin_r;
  logic [14:0] max_ang_r;
  logic [14:0] lin_accel_r;
  logic [14:0] lin_decel_r;
  logic [15:0] cmd_timeout_r;
  logic [15:0] pose_timeout_r;

  // Tick state
  logic [1:0]         state_r;
  logic [15:0]        cmd_age_r;
  logic [15:0]        cmd_age_nxt;
  logic [15:0]        pose_age_r;
  logic [15:0]        pose_age_nxt;
  logic [14:0]        last_lin_r;
  logic signed [15:0] last_ang_r;

  // Captured tick
  logic signed [15:0] in_v_r;
  logic signed [15:0] in_w_r;
  logic               goal_r;
  logic               emerg_r;
  logic               soft_r;
  logic               cmd_old_r;
  logic               pose_old_r;
  logic [15:0]        clear_r;

  // Result register
  out_item_t out_r;
  logic      out_tvalid_r;

  in_item_t  in_item;
  md_req_t   md_req;
  md_rsp_t   md_rsp;
  logic      in_fire;
  logic      out_free;
  logic      commit;
  logic      front_hit;
  logic [15:0] clear_now;
  logic      emerg_now;
  logic      ramp;
  out_item_t res;

  logic signed [16:0] lin_src;
  logic signed [16:0] lin_tgt;
  logic signed [16:0] lin_prev;
  logic signed [16:0] lin_up;
  logic signed [16:0] lin_dn;
  logic signed [16:0] lin_res;
  logic signed [16:0] ang_src;
  logic signed [16:0] ang_tgt;
  logic signed [16:0] ang_max;
  logic signed [16:0] ang_prev;
  logic signed [16:0] ang_up;
  logic signed [16:0] ang_dn;
  logic signed [16:0] ang_res;

  assign in_item   = in_item_t'(in_tdata);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign commit    = (state_r == ST_FIN) && out_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_dist_r    <= RST_SOFT_DIST;
      emerg_dist_r   <= RST_EMERG_DIST;
      max_lin_r      <= RST_MAX_LINEAR;
      max_ang_r      <= RST_MAX_ANGULAR;
      lin_accel_r    <= RST_LIN_ACCEL;
      lin_decel_r    <= RST_LIN_DECEL;
      cmd_timeout_r  <= RST_CMD_TIMEOUT;
      pose_timeout_r <= RST_POSE_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SOFT_DIST:    soft_dist_r    <= cfg_wdata;
        REG_EMERG_DIST:   emerg_dist_r   <= cfg_wdata;
        REG_MAX_LINEAR:   max_lin_r      <= cfg_wdata[14:0];
        REG_MAX_ANGULAR:  max_ang_r      <= cfg_wdata[14:0];
        REG_LIN_ACCEL:    lin_accel_r    <= cfg_wdata[14:0];
        REG_LIN_DECEL:    lin_decel_r    <= cfg_wdata[14:0];
        REG_CMD_TIMEOUT:  cmd_timeout_r  <= cfg_wdata;
        REG_POSE_TIMEOUT: pose_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the saturating age counters
  assign cmd_age_nxt  = in_item.cmd_new ? 16'd0 :
                        (cmd_age_r == AGE_MAX) ? AGE_MAX : cmd_age_r + 16'd1;
  assign pose_age_nxt = in_item.pose_new ? 16'd0 :
                        (pose_age_r == AGE_MAX) ? AGE_MAX : pose_age_r + 16'd1;

  // Find the front clearance and the emergency condition of the incoming tick
  assign front_hit = in_item.obstacle_valid &&
                     (in_item.obstacle_azimuth <= FRONT_HALF_ANGLE_MRAD) &&
                     (in_item.obstacle_azimuth >= -FRONT_HALF_ANGLE_MRAD);
  assign clear_now = front_hit ? in_item.obstacle_distance : NO_CLEARANCE;
  assign emerg_now = clear_now < emerg_dist_r;

  // Start the scaling unit on every accepted tick
  assign md_req.start   = in_fire;
  assign md_req.mcand   = in_item.cmd_linear[14:0];
  assign md_req.mplier  = clear_now;
  assign md_req.divisor = soft_dist_r;

  vcsl_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // Capture the tick
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_v_r     <= in_item.cmd_present ? in_item.cmd_linear : 16'sd0;
      in_w_r     <= in_item.cmd_present ? in_item.cmd_angular : 16'sd0;
      goal_r     <= in_item.goal_is_reached;
      emerg_r    <= emerg_now;
      soft_r     <= !emerg_now && (clear_now < soft_dist_r);
      cmd_old_r  <= cmd_age_nxt > cmd_timeout_r;
      pose_old_r <= pose_age_nxt > pose_timeout_r;
      clear_r    <= clear_now;
    end
  end

  // Linear target: ramp to zero, soft-stop scaling, then clamp to 0..max
  assign ramp = cmd_old_r || pose_old_r || goal_r;

  always_comb begin
    if (ramp) begin
      lin_src = 17'sd0;
    end else if (soft_r) begin
      lin_src = (in_v_r > 16'sd0) ? $signed({2'b00, md_rsp.quotient}) : 17'sd0;
    end else begin
      lin_src = 17'(in_v_r);
    end
    if (lin_src < 17'sd0) begin
      lin_tgt = 17'sd0;
    end else if (lin_src > $signed({2'b00, max_lin_r})) begin
      lin_tgt = $signed({2'b00, max_lin_r});
    end else begin
      lin_tgt = lin_src;
    end
  end

  // Linear slew
  assign lin_prev = $signed({2'b00, last_lin_r});
  assign lin_up   = lin_prev + $signed({2'b00, lin_accel_r});
  assign lin_dn   = lin_prev - $signed({2'b00, lin_decel_r});

  always_comb begin
    if (lin_tgt > lin_prev) begin
      lin_res = (lin_up < lin_tgt) ? lin_up : lin_tgt;
    end else if (lin_tgt < lin_prev) begin
      lin_res = (lin_dn > lin_tgt) ? lin_dn : lin_tgt;
    end else begin
      lin_res = lin_tgt;
    end
  end

  // Angular target clamped to plus or minus max, then slew by the fixed step
  assign ang_src  = ramp ? 17'sd0 : 17'(in_w_r);
  assign ang_max  = $signed({2'b00, max_ang_r});
  assign ang_prev = 17'(last_ang_r);
  assign ang_up   = ang_prev + ANGULAR_STEP;
  assign ang_dn   = ang_prev - ANGULAR_STEP;

  always_comb begin
    if (ang_src < -ang_max) begin
      ang_tgt = -ang_max;
    end else if (ang_src > ang_max) begin
      ang_tgt = ang_max;
    end else begin
      ang_tgt = ang_src;
    end
    if (ang_tgt > ang_prev) begin
      ang_res = (ang_up < ang_tgt) ? ang_up : ang_tgt;
    end else if (ang_tgt < ang_prev) begin
      ang_res = (ang_dn > ang_tgt) ? ang_dn : ang_tgt;
    end else begin
      ang_res = ang_tgt;
    end
  end

  // Assemble the result transaction
  always_comb begin
    res = '0;
    if (!ramp && emerg_r) begin
      res.out_linear  = '0;
      res.out_angular = '0;
    end else begin
      res.out_linear  = lin_res[14:0];
      res.out_angular = ang_res[15:0];
    end
    res.emergency_active = emerg_r;
    res.soft_stop_active = soft_r;
    res.command_stale    = cmd_old_r;
    res.pose_is_stale    = pose_old_r;
    res.goal_flag        = goal_r;
    res.obstacle_close   = emerg_r || soft_r;
    res.move_ok          = !emerg_r && !cmd_old_r && !pose_old_r;
    res.front_dist       = clear_r;
    priority if (emerg_r) begin
      res.reason_code = RSN_EMERGENCY;
    end else if (cmd_old_r) begin
      res.reason_code = RSN_CMD_STALE;
    end else if (pose_old_r) begin
      res.reason_code = RSN_POSE_STALE;
    end else if (goal_r) begin
      res.reason_code = RSN_GOAL;
    end else if (soft_r) begin
      res.reason_code = RSN_SOFT_STOP;
    end else begin
      res.reason_code = RSN_NORMAL;
    end
  end

  // Sequence the tick and hold the tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cmd_age_r    <= '0;
      pose_age_r   <= '0;
      last_lin_r   <= '0;
      last_ang_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the transaction is taken
      if (commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_age_r  <= cmd_age_nxt;
            pose_age_r <= pose_age_nxt;
            state_r    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (md_rsp.done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (commit) begin
            last_lin_r <= res.out_linear;
            last_ang_r <= res.out_angular;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= res;
    end
  end

  assign out_tdata  = out_r;
  assign out_tvalid = out_tvalid_r;

`ifndef SYNTHESIS
  // The scaling unit reports only while a tick is running
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> state_r == ST_RUN)
    else $error("scaling result outside a running tick");

  // An emergency without a ramp request stops both speeds at once
  a_emerg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_r.emergency_active && !out_r.command_stale &&
     !out_r.pose_is_stale && !out_r.goal_flag)
    |-> (out_r.out_linear == '0 && out_r.out_angular == '0))
    else $error("emergency result with nonzero speed");

  // A finished tick reaches the output register and frees the input side
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_tvalid_r && state_r == ST_IDLE && last_lin_r == out_r.out_linear))
    else $error("finished tick not delivered");
`endif

endmodule

/* hw/rtl/vcsl_muldiv.sv */
// Serial shift-add multiplier followed by a restoring divider for the soft-stop ratio.
module vcsl_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  vcsl_pkg::md_req_t req,
  output vcsl_pkg::md_rsp_t rsp
);
  import vcsl_pkg::*;

  logic             busy_r;
  logic             div_phase_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [14:0]      mcand_r;
  logic [15:0]      mplier_r;
  logic [15:0]      divisor_r;
  logic [30:0]      acc_r;
  logic [30:0]      acc_nxt;
  logic [16:0]      rem_r;
  logic [16:0]      rem_sh;
  logic [16:0]      rem_sub;
  logic             rem_ge;
  logic [14:0]      low_r;
  logic [14:0]      quo_r;

  // Multiply step: one multiplier bit per cycle, most significant first
  assign acc_nxt = {acc_r[29:0], 1'b0} + (mplier_r[15] ? {16'd0, mcand_r} : 31'd0);

  // Divide step: one quotient bit per cycle
  assign rem_sh  = {rem_r[15:0], low_r[14]};
  assign rem_ge  = rem_sh >= {1'b0, divisor_r};
  assign rem_sub = rem_sh - {1'b0, divisor_r};

  // Sequence the multiply and divide phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      div_phase_r <= 1'b0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
    end else if (req.start) begin
      busy_r      <= 1'b1;
      div_phase_r <= 1'b0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
    end else if (busy_r) begin
      if (!div_phase_r) begin
        if (cnt_r == MUL_LAST) begin
          div_phase_r <= 1'b1;
          cnt_r       <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else begin
        if (cnt_r == DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Shift the operands, partial product, remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r   <= req.mcand;
      mplier_r  <= req.mplier;
      divisor_r <= req.divisor;
      acc_r     <= '0;
    end else if (busy_r && !div_phase_r) begin
      acc_r    <= acc_nxt;
      mplier_r <= {mplier_r[14:0], 1'b0};
      if (cnt_r == MUL_LAST) begin
        rem_r <= {1'b0, acc_nxt[30:15]};
        low_r <= acc_nxt[14:0];
      end
    end else if (busy_r) begin
      rem_r <= rem_ge ? rem_sub : rem_sh;
      low_r <= {low_r[13:0], 1'b0};
      quo_r <= {quo_r[13:0], rem_ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef SYNTHESIS
  // A new request never lands on an operation in flight
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("scaling unit started while busy");

  // Completion follows only the last divide step
  a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r && div_phase_r && cnt_r == DIV_LAST))
    else $error("scaling unit finished outside the divide phase");

  // Completion is never reported while still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("scaling unit done while busy");
`endif

endmodule
